@@ design/vpls_pkg.sv @@
// Package for the VL-SNR pilot layout sequencer: types, constants and step helpers.
package vpls_pkg;

	localparam int unsigned DataW    = 16;
	localparam int unsigned PosW     = 17;
	localparam int unsigned PcntW    = 16;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned SlotW    = 10;
	localparam int unsigned OffW     = 7;
	localparam int unsigned SscW     = 4;
	localparam int unsigned GroupW   = 5;
	localparam int unsigned GcntW    = 11;
	localparam int unsigned RunW     = 8;
	localparam int unsigned LenW     = 6;
	localparam int unsigned SumW     = DataW + 1;
	localparam int unsigned DivShift = 23;
	localparam int unsigned ProdW    = 2 * SumW;

	localparam logic [CfgIdxW-1:0] CfgDataSymbols = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgSetSelect   = 2'd1;

	localparam logic [SumW-1:0]   ExtraSet1    = 17'(18 * 34 + 3 * 36);
	localparam logic [SumW-1:0]   ExtraSet2    = 17'(9 * 32 + 36);
	// ceil(2^23 / 90): exact floor division by 90 for any 17-bit sum
	localparam logic [SumW-1:0]   DivMul       = 17'd93207;
	localparam logic [OffW-1:0]   SlotLen      = 7'd90;
	localparam logic [GcntW-1:0]  ThrSet1A     = 11'd703;
	localparam logic [GcntW-1:0]  ThrB         = 11'd702;
	localparam logic [GcntW-1:0]  ThrSet2A     = 11'd704;
	localparam logic [GcntW-1:0]  GcntMax      = 11'd2047;
	localparam logic [LenW-1:0]   LenSet1A     = 6'd34;
	localparam logic [LenW-1:0]   LenB         = 6'd36;
	localparam logic [LenW-1:0]   LenSet2A     = 6'd32;
	localparam logic [RunW-1:0]   BoundaryLen  = 8'd36;
	localparam logic [RunW-1:0]   TailBase     = 8'd179;
	localparam logic [SscW-1:0]   CounterStart = 4'd10;
	localparam logic [GroupW-1:0] GroupMax     = 5'd31;
	localparam logic [GroupW-1:0] Set1LastA    = 5'd18;
	localparam logic [GroupW-1:0] Set1FirstB   = 5'd19;
	localparam logic [GroupW-1:0] Set1LastB    = 5'd21;
	localparam logic [GroupW-1:0] Set2LastA    = 5'd9;
	localparam logic [GroupW-1:0] Set2B        = 5'd10;

	typedef enum logic [2:0] {
		PH_DATA,
		PH_GPILOT,
		PH_TAIL,
		PH_BOUND,
		PH_DONE
	} vpls_phase_t;

	typedef struct packed {
		logic [DataW-1:0] data_symbols;
		logic             set_select;
	} vpls_cfg_t;

	typedef struct packed {
		logic [SlotW-1:0]  slot_index;
		logic [SlotW-1:0]  slot_total;
		logic [OffW-1:0]   slot_offset;
		logic [SscW-1:0]   ssc;
		logic [GroupW-1:0] group_number;
		logic [GcntW-1:0]  group_count;
		vpls_phase_t       phase;
		logic [RunW-1:0]   run_remaining;
		logic [PosW-1:0]   symbol_position;
		logic [PcntW-1:0]  pilot_total;
		logic              frame_set;
	} vpls_state_t;

	typedef struct packed {
		logic             pilot_flag;
		logic [PosW-1:0]  position;
		logic [PcntW-1:0] pilot_count;
		logic             last_symbol;
	} vpls_res_t;

	function automatic logic [SlotW-1:0] slot_total_of(input logic [DataW-1:0] data,
			input logic set1);
		logic [SumW-1:0]  sum;
		logic [ProdW-1:0] prod;
		sum  = {1'b0, data} + (set1 ? ExtraSet1 : ExtraSet2);
		prod = {{SumW{1'b0}}, sum} * {{SumW{1'b0}}, DivMul};
		return prod[DivShift +: SlotW];
	endfunction

	function automatic logic [GcntW-1:0] bump_count(input logic [GcntW-1:0] c);
		return (c < GcntMax) ? c + 11'd1 : c;
	endfunction

	function automatic logic [LenW-1:0] plen_for_group(input logic set1,
			input logic [GroupW-1:0] g);
		if (set1)
			return (g <= Set1LastA) ? LenSet1A : LenB;
		return (g <= Set2LastA) ? LenSet2A : LenB;
	endfunction

	function automatic logic [LenW-1:0] fire_len(input logic set1,
			input logic [GroupW-1:0] g, input logic [GcntW-1:0] s);
		logic [LenW-1:0] len;
		len = '0;
		if (set1) begin
			if (g <= Set1LastA && s == ThrSet1A)
				len = LenSet1A;
			else if (g >= Set1FirstB && g <= Set1LastB && s == ThrB)
				len = LenB;
		end else begin
			if (g <= Set2LastA && s == ThrSet2A)
				len = LenSet2A;
			else if (g == Set2B && s == ThrB)
				len = LenB;
		end
		return len;
	endfunction

	function automatic vpls_state_t end_slot(input vpls_state_t s);
		vpls_state_t       r;
		logic [SlotW:0]    idx_inc;
		r       = s;
		r.ssc   = s.ssc + 4'd1;
		idx_inc = {1'b0, s.slot_index} + 11'd1;
		r.slot_index = idx_inc[SlotW-1:0];
		if (r.ssc == '0 && idx_inc < {1'b0, s.slot_total}) begin
			if (s.group_number < GroupMax)
				r.group_number = s.group_number + 5'd1;
			r.group_count   = '0;
			r.run_remaining = BoundaryLen;
			r.phase         = PH_BOUND;
		end else if (r.slot_index < s.slot_total) begin
			r.slot_offset = '0;
			r.phase       = PH_DATA;
		end else begin
			r.phase = PH_DONE;
		end
		return r;
	endfunction

endpackage

@@ design/vpls_cfg_regs.sv @@
// Configuration register bank: data symbol count and set select.
module vpls_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [vpls_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [vpls_pkg::DataW-1:0]     cfg_data,
	output vpls_pkg::vpls_cfg_t            cfg
);

	vpls_pkg::vpls_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_symbols <= '0;
			cfg_q.set_select   <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				vpls_pkg::CfgDataSymbols: cfg_q.data_symbols <= cfg_data;
				vpls_pkg::CfgSetSelect:   cfg_q.set_select   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/vpls_step.sv @@
// Single-item step: frame start, symbol classification and layout state update.
module vpls_step (
	input  vpls_pkg::vpls_state_t st,
	input  logic                  restart,
	input  vpls_pkg::vpls_cfg_t   cfg,
	output vpls_pkg::vpls_state_t nxt,
	output vpls_pkg::vpls_res_t   res,
	output logic                  has_res
);

	vpls_pkg::vpls_state_t eff;
	logic                  pil;
	logic [vpls_pkg::SlotW-1:0] total_new;

	assign total_new = vpls_pkg::slot_total_of(cfg.data_symbols, cfg.set_select);

	always_comb begin
		eff = st;
		if (restart) begin
			eff.frame_set       = cfg.set_select;
			eff.slot_total      = total_new;
			eff.slot_index      = '0;
			eff.slot_offset     = '0;
			eff.ssc             = vpls_pkg::CounterStart;
			eff.group_number    = '0;
			eff.group_count     = '0;
			eff.run_remaining   = '0;
			eff.symbol_position = '0;
			eff.pilot_total     = '0;
			eff.phase = (total_new != '0) ? vpls_pkg::PH_DATA : vpls_pkg::PH_DONE;
		end
	end

	assign pil = (eff.phase == vpls_pkg::PH_GPILOT) || (eff.phase == vpls_pkg::PH_BOUND);

	// next state
	always_comb begin
		logic [vpls_pkg::LenW-1:0] plen;
		plen = '0;
		nxt  = eff;
		nxt.pilot_total     = eff.pilot_total + 16'(pil);
		nxt.symbol_position = eff.symbol_position + 17'd1;
		unique case (eff.phase)
			vpls_pkg::PH_DATA: begin
				nxt.group_count = vpls_pkg::bump_count(eff.group_count);
				plen = vpls_pkg::fire_len(eff.frame_set, eff.group_number, nxt.group_count);
				if (plen != '0) begin
					nxt.run_remaining = 8'(plen);
					nxt.phase         = vpls_pkg::PH_GPILOT;
				end else begin
					nxt.slot_offset = eff.slot_offset + 7'd1;
					if (nxt.slot_offset >= vpls_pkg::SlotLen)
						nxt = vpls_pkg::end_slot(nxt);
				end
			end
			vpls_pkg::PH_GPILOT: begin
				nxt.run_remaining = eff.run_remaining - 8'd1;
				if (nxt.run_remaining == '0) begin
					plen = vpls_pkg::plen_for_group(eff.frame_set, eff.group_number);
					nxt.run_remaining = vpls_pkg::TailBase - 8'(eff.slot_offset) - 8'(plen);
					nxt.phase         = vpls_pkg::PH_TAIL;
				end
			end
			vpls_pkg::PH_TAIL: begin
				nxt.group_count   = vpls_pkg::bump_count(eff.group_count);
				nxt.run_remaining = eff.run_remaining - 8'd1;
				if (nxt.run_remaining == '0) begin
					nxt.ssc        = eff.ssc + 4'd1;
					nxt.slot_index = eff.slot_index + 10'd1;
					nxt = vpls_pkg::end_slot(nxt);
				end
			end
			vpls_pkg::PH_BOUND: begin
				nxt.run_remaining = eff.run_remaining - 8'd1;
				if (nxt.run_remaining == '0) begin
					nxt.slot_offset = '0;
					nxt.phase       = vpls_pkg::PH_DATA;
				end
			end
			default: begin
				nxt       = eff;
				nxt.phase = vpls_pkg::PH_DONE;
			end
		endcase
	end

	// outputs
	always_comb begin
		has_res         = (eff.phase != vpls_pkg::PH_DONE);
		res.pilot_flag  = pil;
		res.position    = eff.symbol_position;
		res.pilot_count = eff.pilot_total + 16'(pil);
		res.last_symbol = (nxt.phase == vpls_pkg::PH_DONE);
	end

endmodule

@@ design/vlsnr_pilot_layout_sequencer_unit.sv @@
// Top level of the VL-SNR pilot layout sequencer.
//
// Each item on the input channel (in_valid/in_ready, field restart) is one
// symbol tick. restart=1 starts a new frame using the data_symbols and
// set_select registers and gives symbol 0; restart=0 gives the next symbol.
// Ticks while no frame runs give no result item.
// Result items (out_valid/out_ready) carry pilot_flag, position, pilot_count
// and last_symbol.
// The block is a two-register pipeline: an input register, then the layout
// state and the result register, updated together by one pass of logic.
// Throughput: one item per cycle while the receiver does not stall.
// The user must write configuration through cfg_wr_en/cfg_index/cfg_data
// only while no item is in flight; the block itself does not enforce
// this. Index 0 is data_symbols, index 1 is set_select.
// After reset no frame runs, data_symbols is 0 and set_select is 1 (SET1).
// When the receiver stalls, the result register holds; the input register
// still takes one item if it is empty, and then in_ready drops.
module vlsnr_pilot_layout_sequencer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         pilot_flag,
	output logic [vpls_pkg::PosW-1:0]    position,
	output logic [vpls_pkg::PcntW-1:0]   pilot_count,
	output logic                         last_symbol,
	input  logic                         cfg_wr_en,
	input  logic [vpls_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [vpls_pkg::DataW-1:0]   cfg_data
);

	vpls_pkg::vpls_cfg_t   cfg;
	vpls_pkg::vpls_state_t st_q;
	vpls_pkg::vpls_state_t st_nxt;
	vpls_pkg::vpls_res_t   res;
	vpls_pkg::vpls_res_t   res_s2;
	logic                  has_res;
	logic                  valid_s1;
	logic                  restart_s1;
	logic                  valid_s2;
	logic                  adv_s2;
	logic                  fire_s1;

	vpls_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vpls_step u_step (
		.st      (st_q),
		.restart (restart_s1),
		.cfg     (cfg),
		.nxt     (st_nxt),
		.res     (res),
		.has_res (has_res)
	);

	assign adv_s2   = !valid_s2 || out_ready;
	assign fire_s1  = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			restart_s1 <= restart;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= fire_s1 && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && adv_s2)
			res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.slot_index      <= '0;
			st_q.slot_total      <= '0;
			st_q.slot_offset     <= '0;
			st_q.ssc             <= vpls_pkg::CounterStart;
			st_q.group_number    <= '0;
			st_q.group_count     <= '0;
			st_q.phase           <= vpls_pkg::PH_DONE;
			st_q.run_remaining   <= '0;
			st_q.symbol_position <= '0;
			st_q.pilot_total     <= '0;
			st_q.frame_set       <= 1'b1;
		end else if (fire_s1) begin
			st_q <= st_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign pilot_flag  = res_s2.pilot_flag;
	assign position    = res_s2.position;
	assign pilot_count = res_s2.pilot_count;
	assign last_symbol = res_s2.last_symbol;

endmodule
